// ----- src/espi_pkg.sv -----
// ----------------------------------------------------------------------------
// espi_pkg
// Shared types and constants of the exposure shutter/gain PI controller.
// ----------------------------------------------------------------------------
package espi_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET_LEVEL     = 3'd0,
      CSR_DEAD_BAND        = 3'd1,
      CSR_SHUTTER_MIN_US   = 3'd2,
      CSR_SHUTTER_MAX_US   = 3'd3,
      CSR_GAIN_MAX_DB      = 3'd4,
      CSR_GAIN_SWITCH_US   = 3'd5,
      CSR_SHUTTER_INT_COEF = 3'd6,
      CSR_GAIN_INT_COEF    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [11:0] target_level;
      logic [11:0] dead_band;
      logic [15:0] shutter_min_us;
      logic [15:0] shutter_max_us;
      logic [5:0]  gain_max_db;
      logic [15:0] gain_switch_us;
      logic [15:0] shutter_int_coef;
      logic [15:0] gain_int_coef;
   } cfg_type;

   // multiply/divide unit
   localparam int MDU_A_W   = 31;
   localparam int MDU_B_W   = 16;
   localparam int MDU_RES_W = 37;

   typedef enum logic {
      MDU_MUL = 1'b0,
      MDU_DIV = 1'b1
   } mdu_op_type;

   typedef struct packed {
      logic       start;
      mdu_op_type op;
   } mdu_ctrl_type;

   // 0.01 dB per pixel unit in Q0.16
   localparam logic [15:0] GAIN_P_COEF    = 16'd655;
   localparam logic [19:0] GAIN_INT_LIMIT = 20'hFFFFF;

   localparam logic [21:0] SHUTTER_INT_RST = 22'd160;
   localparam logic [20:0] SHUTTER_VAL_RST = 21'd160000;
   localparam logic [13:0] GAIN_VAL_RST    = 14'd768;

endpackage

// ----- src/espi_csr.sv -----
// ----------------------------------------------------------------------------
// espi_csr
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module espi_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [espi_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [espi_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   output espi_pkg::cfg_type                  cfg
);

   espi_pkg::cfg_type cfg_ff;
   espi_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (espi_pkg::csr_index_type'(csr_index))
            espi_pkg::CSR_TARGET_LEVEL:     cfg_in.target_level     = csr_wr_data[11:0];
            espi_pkg::CSR_DEAD_BAND:        cfg_in.dead_band        = csr_wr_data[11:0];
            espi_pkg::CSR_SHUTTER_MIN_US:   cfg_in.shutter_min_us   = csr_wr_data;
            espi_pkg::CSR_SHUTTER_MAX_US:   cfg_in.shutter_max_us   = csr_wr_data;
            espi_pkg::CSR_GAIN_MAX_DB:      cfg_in.gain_max_db      = csr_wr_data[5:0];
            espi_pkg::CSR_GAIN_SWITCH_US:   cfg_in.gain_switch_us   = csr_wr_data;
            espi_pkg::CSR_SHUTTER_INT_COEF: cfg_in.shutter_int_coef = csr_wr_data;
            espi_pkg::CSR_GAIN_INT_COEF:    cfg_in.gain_int_coef    = csr_wr_data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_level     <= 12'd1600;
         cfg_ff.dead_band        <= 12'd80;
         cfg_ff.shutter_min_us   <= 16'd11;
         cfg_ff.shutter_max_us   <= 16'd20000;
         cfg_ff.gain_max_db      <= 6'd48;
         cfg_ff.gain_switch_us   <= 16'd20000;
         cfg_ff.shutter_int_coef <= 16'd256;
         cfg_ff.gain_int_coef    <= 16'd3604;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/espi_mdu.sv -----
// ----------------------------------------------------------------------------
// espi_mdu
// Serial unsigned multiply (16 steps, shift-add) and restoring divide
// (31 steps) sharing one adder. done stays high until the next start.
// ----------------------------------------------------------------------------
module espi_mdu (
   input  logic                              clock,
   input  logic                              reset,
   input  espi_pkg::mdu_ctrl_type            ctrl,
   input  logic [espi_pkg::MDU_A_W-1:0]      op_a,
   input  logic [espi_pkg::MDU_B_W-1:0]      op_b,
   output logic                              done,
   output logic [espi_pkg::MDU_RES_W-1:0]    result
);

   localparam logic [4:0] MUL_LAST = 5'd15;
   localparam logic [4:0] DIV_LAST = 5'd30;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   espi_pkg::mdu_op_type   op_ff, op_in;
   logic [4:0]             cnt_ff, cnt_in;
   logic [30:0]            a_ff, a_in;
   logic [15:0]            b_ff, b_in;
   logic [31:0]            acc_ff, acc_in;
   logic [30:0]            sh_ff, sh_in;

   logic [32:0]            add_x;
   logic [32:0]            add_y;
   logic                   add_cin;
   logic [32:0]            add_sum;
   logic                   div_ok;
   logic                   last;

   always_comb begin
      if (op_ff == espi_pkg::MDU_MUL) begin
         add_x   = {1'b0, acc_ff};
         add_y   = sh_ff[0] ? {2'b0, a_ff} : 33'd0;
         add_cin = 1'b0;
      end else begin
         add_x   = {16'd0, acc_ff[15:0], sh_ff[30]};
         add_y   = ~{17'd0, b_ff};
         add_cin = 1'b1;
      end
      add_sum = add_x + add_y + {32'd0, add_cin};
   end

   assign div_ok = ~add_sum[32];
   assign last   = (op_ff == espi_pkg::MDU_MUL) ? (cnt_ff == MUL_LAST) : (cnt_ff == DIV_LAST);

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         op_in   = ctrl.op;
         cnt_in  = 5'd0;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = 32'd0;
         sh_in   = (ctrl.op == espi_pkg::MDU_MUL) ? {15'd0, op_b} : op_a;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (op_ff == espi_pkg::MDU_MUL) begin
            acc_in = add_sum[32:1];
            sh_in  = {add_sum[0], sh_ff[30:1]};
         end else begin
            acc_in = div_ok ? {16'd0, add_sum[15:0]} : {16'd0, acc_ff[14:0], sh_ff[30]};
            sh_in  = {sh_ff[29:0], div_ok};
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
   end

   assign done   = done_ff;
   assign result = (op_ff == espi_pkg::MDU_MUL) ? {acc_ff[20:0], sh_ff[30:15]}
                                                : {6'd0, sh_ff};

endmodule

// ----- src/exposure_shutter_gain_pi_controller_core.sv -----
// ----------------------------------------------------------------------------
// exposure_shutter_gain_pi_controller_core
// Takes one mean frame brightness (Q8.4) per beat and returns one beat with
// the new shutter time, whether the shutter loop ran, the sensor gain (dB,
// Q6.8) and the active mode. A beat runs only the shutter loop, only the
// gain PI or the proportional gain, or the shutter loop before the gain PI
// or the proportional gain in the same beat; a negative gain integral drops
// a gain mode beat back to shutter mode. All products and the quotient come
// from the shared serial multiplier and divider; a previous result still
// stalled at the output holds the new result back until it is taken.
// req_stall is high while a beat is being worked on; a finished result waits
// in the output register while the next beat is taken. Configuration must be
// written through csr_wr_en/csr_index/csr_wr_data only while idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module exposure_shutter_gain_pi_controller_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [espi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [espi_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [11:0]                       req_mean_level,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [15:0]                       rsp_shutter_us,
   output logic                              rsp_shutter_updated,
   output logic [13:0]                       rsp_gain_level,
   output logic                              rsp_gain_mode
);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_SMUL  = 12'b0000_0000_0010,
      S_SINT  = 12'b0000_0000_0100,
      S_SVAL  = 12'b0000_0000_1000,
      S_MODE  = 12'b0000_0001_0000,
      S_GMUL1 = 12'b0000_0010_0000,
      S_GINT  = 12'b0000_0100_0000,
      S_GMUL2 = 12'b0000_1000_0000,
      S_GPI   = 12'b0001_0000_0000,
      S_PMUL  = 12'b0010_0000_0000,
      S_PDIV  = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   espi_pkg::cfg_type       cfg;
   espi_pkg::mdu_ctrl_type  mdu_ctrl;
   logic [30:0]             mdu_a;
   logic [15:0]             mdu_b;
   logic                    mdu_done;
   logic [36:0]             mdu_result;

   state_type               state_ff, state_in;
   logic signed [21:0]      si_ff, si_in;
   logic [20:0]             sv_ff, sv_in;
   logic signed [20:0]      gi_ff, gi_in;
   logic [13:0]             gv_ff, gv_in;
   logic                    mode_ff, mode_in;
   logic                    ran_ff, ran_in;
   logic signed [12:0]      err_ff, err_in;
   logic [11:0]             errmag_ff, errmag_in;
   logic signed [21:0]      rnd_ff, rnd_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_shutter_us_ff, rsp_shutter_us_in;
   logic                    rsp_shutter_updated_ff, rsp_shutter_updated_in;
   logic [13:0]             rsp_gain_level_ff, rsp_gain_level_in;
   logic                    rsp_gain_mode_ff, rsp_gain_mode_in;

   logic signed [12:0]      err_raw;
   logic signed [12:0]      err_raw_neg;
   logic [11:0]             mag_raw;
   logic                    in_band;

   logic [19:0]             smax16;
   logic [19:0]             smin16;
   logic [19:0]             gsw16;
   logic [13:0]             gmax256;
   logic signed [22:0]      smax_s;
   logic signed [22:0]      smin_s;
   logic signed [22:0]      gmax_s;
   logic signed [22:0]      glim_s;

   logic signed [29:0]      prod_mag;
   logic signed [29:0]      prod_s;
   logic signed [29:0]      prod_r8;
   logic signed [29:0]      prod_r12;
   logic signed [21:0]      rnd8;
   logic signed [21:0]      rnd12;

   logic signed [22:0]      isum;
   logic signed [22:0]      iclamp;
   logic signed [22:0]      vsum;
   logic signed [22:0]      vmax;
   logic signed [22:0]      vclamp;
   logic signed [22:0]      gsum;
   logic signed [22:0]      gclamp;
   logic [13:0]             gpi_val;

   logic signed [22:0]      over;
   logic signed [22:0]      over_neg;
   logic [20:0]             over_mag;
   logic signed [16:0]      den;
   logic signed [16:0]      den_neg;
   logic [15:0]             den_mag;
   logic [13:0]             prop_val;
   logic                    mode_next;

   espi_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   espi_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mdu_ctrl),
      .op_a   (mdu_a),
      .op_b   (mdu_b),
      .done   (mdu_done),
      .result (mdu_result)
   );

   // error with deadband
   assign err_raw     = $signed({1'b0, cfg.target_level}) - $signed({1'b0, req_mean_level});
   assign err_raw_neg = -err_raw;
   assign mag_raw     = err_raw[12] ? err_raw_neg[11:0] : err_raw[11:0];
   assign in_band     = mag_raw < cfg.dead_band;

   assign smax16  = {cfg.shutter_max_us, 4'd0};
   assign smin16  = {cfg.shutter_min_us, 4'd0};
   assign gsw16   = {cfg.gain_switch_us, 4'd0};
   assign gmax256 = {cfg.gain_max_db, 8'd0};
   assign smax_s  = $signed({3'd0, smax16});
   assign smin_s  = $signed({3'd0, smin16});
   assign gmax_s  = $signed({9'd0, gmax256});
   assign glim_s  = $signed({3'd0, espi_pkg::GAIN_INT_LIMIT});

   // signed product from magnitude, round half up
   assign prod_mag = $signed({2'b0, mdu_result[27:0]});
   assign prod_s   = err_ff[12] ? -prod_mag : prod_mag;
   assign prod_r8  = prod_s + 30'sd128;
   assign prod_r12 = prod_s + 30'sd2048;
   assign rnd8     = prod_r8[29:8];
   assign rnd12    = {{4{prod_r12[29]}}, prod_r12[29:12]};

   // shutter integral and value
   assign isum   = $signed({si_ff[21], si_ff}) + $signed({rnd_ff[21], rnd_ff});
   assign iclamp = (isum > smax_s) ? smax_s : ((isum < -smax_s) ? -smax_s : isum);
   assign vsum   = $signed({si_ff[21], si_ff}) + $signed({{10{err_ff[12]}}, err_ff});
   assign vmax   = (vsum > smax_s) ? smax_s : vsum;
   assign vclamp = (vmax < smin_s) ? smin_s : vmax;

   // gain integral, and the PI sum on the updated integral
   assign gsum    = $signed({{2{gi_ff[20]}}, gi_ff}) + $signed({rnd_ff[21], rnd_ff});
   assign gclamp  = (gsum > glim_s) ? glim_s : ((gsum < -glim_s) ? -glim_s : gsum);
   assign gpi_val = gsum[22] ? 14'd0 : ((gsum > gmax_s) ? gmax256 : gsum[13:0]);

   // proportional gain from shutter overshoot
   assign over     = $signed({2'b0, sv_ff}) - $signed({3'b0, gsw16});
   assign over_neg = -over;
   assign over_mag = over[22] ? over_neg[20:0] : over[20:0];
   assign den      = $signed({1'b0, cfg.shutter_max_us}) - $signed({1'b0, cfg.gain_switch_us});
   assign den_neg  = -den;
   assign den_mag  = den[16] ? den_neg[15:0] : den[15:0];
   assign prop_val = (neg_ff ^ den[16]) ? 14'd0 :
                     ((mdu_result[30:0] > {17'd0, gmax256}) ? gmax256 : mdu_result[13:0]);

   assign mode_next = ((sv_ff >= {1'b0, gsw16}) | mode_ff) & ~gi_ff[20];

   always_comb begin
      state_in               = state_ff;
      si_in                  = si_ff;
      sv_in                  = sv_ff;
      gi_in                  = gi_ff;
      gv_in                  = gv_ff;
      mode_in                = mode_ff;
      ran_in                 = ran_ff;
      err_in                 = err_ff;
      errmag_in              = errmag_ff;
      rnd_in                 = rnd_ff;
      neg_in                 = neg_ff;
      rsp_valid_in           = rsp_valid_ff & rsp_stall;
      rsp_shutter_us_in      = rsp_shutter_us_ff;
      rsp_shutter_updated_in = rsp_shutter_updated_ff;
      rsp_gain_level_in      = rsp_gain_level_ff;
      rsp_gain_mode_in       = rsp_gain_mode_ff;
      mdu_ctrl.start         = 1'b0;
      mdu_ctrl.op            = espi_pkg::MDU_MUL;
      mdu_a                  = 31'd0;
      mdu_b                  = 16'd0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in    = in_band ? 13'sd0 : err_raw;
               errmag_in = in_band ? 12'd0 : mag_raw;
               ran_in    = ~mode_ff;
               if (!mode_ff) begin
                  mdu_ctrl.start = 1'b1;
                  mdu_a          = {19'd0, (in_band ? 12'd0 : mag_raw)};
                  mdu_b          = cfg.shutter_int_coef;
                  state_in       = S_SMUL;
               end else begin
                  state_in = S_MODE;
               end
            end
         end
         S_SMUL: begin
            if (mdu_done) begin
               rnd_in   = rnd8;
               state_in = S_SINT;
            end
         end
         S_SINT: begin
            si_in    = iclamp[21:0];
            state_in = S_SVAL;
         end
         S_SVAL: begin
            sv_in    = vclamp[20:0];
            state_in = S_MODE;
         end
         S_MODE: begin
            mode_in = mode_next;
            if (mode_next) begin
               mdu_ctrl.start = 1'b1;
               if (cfg.gain_switch_us == cfg.shutter_max_us) begin
                  mdu_a    = {19'd0, errmag_ff};
                  mdu_b    = cfg.gain_int_coef;
                  state_in = S_GMUL1;
               end else begin
                  mdu_a    = {10'd0, over_mag};
                  mdu_b    = {10'd0, cfg.gain_max_db};
                  neg_in   = over[22];
                  state_in = S_PMUL;
               end
            end else begin
               gi_in    = 21'sd0;
               gv_in    = 14'd0;
               state_in = S_DONE;
            end
         end
         S_GMUL1: begin
            if (mdu_done) begin
               rnd_in   = rnd12;
               state_in = S_GINT;
            end
         end
         S_GINT: begin
            gi_in          = gclamp[20:0];
            mdu_ctrl.start = 1'b1;
            mdu_a          = {19'd0, errmag_ff};
            mdu_b          = espi_pkg::GAIN_P_COEF;
            state_in       = S_GMUL2;
         end
         S_GMUL2: begin
            if (mdu_done) begin
               rnd_in   = rnd12;
               state_in = S_GPI;
            end
         end
         S_GPI: begin
            gv_in    = gpi_val;
            state_in = S_DONE;
         end
         S_PMUL: begin
            if (mdu_done) begin
               mdu_ctrl.start = 1'b1;
               mdu_ctrl.op    = espi_pkg::MDU_DIV;
               mdu_a          = {mdu_result[26:0], 4'd0};
               mdu_b          = den_mag;
               state_in       = S_PDIV;
            end
         end
         S_PDIV: begin
            if (mdu_done) begin
               gv_in    = prop_val;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_shutter_us_in      = sv_ff[19:4];
               rsp_shutter_updated_in = ran_ff;
               rsp_gain_level_in      = gv_ff;
               rsp_gain_mode_in       = mode_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         si_ff        <= $signed(espi_pkg::SHUTTER_INT_RST);
         sv_ff        <= espi_pkg::SHUTTER_VAL_RST;
         gi_ff        <= 21'sd0;
         gv_ff        <= espi_pkg::GAIN_VAL_RST;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         si_ff        <= si_in;
         sv_ff        <= sv_in;
         gi_ff        <= gi_in;
         gv_ff        <= gv_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ran_ff                 <= ran_in;
      err_ff                 <= err_in;
      errmag_ff              <= errmag_in;
      rnd_ff                 <= rnd_in;
      neg_ff                 <= neg_in;
      rsp_shutter_us_ff      <= rsp_shutter_us_in;
      rsp_shutter_updated_ff <= rsp_shutter_updated_in;
      rsp_gain_level_ff      <= rsp_gain_level_in;
      rsp_gain_mode_ff       <= rsp_gain_mode_in;
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_shutter_us      = rsp_shutter_us_ff;
   assign rsp_shutter_updated = rsp_shutter_updated_ff;
   assign rsp_gain_level      = rsp_gain_level_ff;
   assign rsp_gain_mode       = rsp_gain_mode_ff;

endmodule

// ----- src/espi_chk.sv -----
// ----------------------------------------------------------------------------
// espi_chk
// Port-level checks of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module espi_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_shutter_us,
   input logic        rsp_shutter_updated,
   input logic [13:0] rsp_gain_level,
   input logic        rsp_gain_mode
);

   a_rsp_clear_on_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again without working the beat");

   a_no_gain_in_shutter_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gain_mode |-> rsp_gain_level == 14'd0)
      else $error("nonzero gain reported in shutter mode");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_shutter_us)
         && $stable(rsp_shutter_updated) && $stable(rsp_gain_level)
         && $stable(rsp_gain_mode))
      else $error("stalled result beat changed");

endmodule

bind exposure_shutter_gain_pi_controller_core espi_chk u_espi_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_shutter_us      (rsp_shutter_us),
   .rsp_shutter_updated (rsp_shutter_updated),
   .rsp_gain_level      (rsp_gain_level),
   .rsp_gain_mode       (rsp_gain_mode)
);

// ----- bench/exposure_result_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exposure_result_monitor
// Watches the register port and both beat channels of the exposure core,
// tracks its own copy of the registers and of the shutter/gain loop state,
// works out the result of every accepted frame and compares each returned
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module exposure_result_monitor
   import espi_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [11:0]           req_mean_level,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [15:0]           rsp_shutter_us,
   input  logic                  rsp_shutter_updated,
   input  logic [13:0]           rsp_gain_level,
   input  logic                  rsp_gain_mode,
   output int                    mismatches,
   output logic                  busy
);

   localparam longint GAIN_ACC_LIMIT = 1048575;
   localparam longint GAIN_P_FACTOR  = 655;

   typedef struct packed {
      logic [15:0] shutter_us;
      logic        shutter_updated;
      logic [13:0] gain_level;
      logic        gain_mode;
   } sensor_setting_type;

   cfg_type            regs;
   longint             shutter_acc;
   longint             shutter_q4;
   longint             gain_acc;
   longint             gain_q8;
   bit                 gain_loop_on;
   sensor_setting_type sensor_setting_q[$];
   sensor_setting_type predicted;
   sensor_setting_type returned;
   int                 frames_in;
   int                 frames_out;

   assign busy = (frames_in != frames_out);

   function automatic longint round_down_shift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   task automatic restore_defaults();
      regs.target_level     = 12'd1600;
      regs.dead_band        = 12'd80;
      regs.shutter_min_us   = 16'd11;
      regs.shutter_max_us   = 16'd20000;
      regs.gain_max_db      = 6'd48;
      regs.gain_switch_us   = 16'd20000;
      regs.shutter_int_coef = 16'd256;
      regs.gain_int_coef    = 16'd3604;
      shutter_acc  = 160;
      shutter_q4   = 160000;
      gain_acc     = 0;
      gain_q8      = 768;
      gain_loop_on = 1'b0;
   endtask

   task automatic run_exposure_step(input logic [11:0] mean, output sensor_setting_type res);
      longint err, mag, smax, smin, gmax, sw16, g, over, span, sh;
      bit     ran;
      err  = longint'(regs.target_level) - longint'(mean);
      mag  = (err < 0) ? -err : err;
      smax = longint'(regs.shutter_max_us) * 16;
      smin = longint'(regs.shutter_min_us) * 16;
      gmax = longint'(regs.gain_max_db) * 256;
      sw16 = longint'(regs.gain_switch_us) * 16;
      ran  = 1'b0;
      if (mag < longint'(regs.dead_band)) err = 0;

      if (!gain_loop_on) begin
         ran = 1'b1;
         shutter_acc += round_down_shift(err * longint'(regs.shutter_int_coef), 8);
         if (shutter_acc > smax) shutter_acc = smax;
         if (shutter_acc < -smax) shutter_acc = -smax;
         shutter_q4 = shutter_acc + err;
         if (shutter_q4 > smax) shutter_q4 = smax;
         if (shutter_q4 < smin) shutter_q4 = smin;
      end

      if (shutter_q4 >= sw16) gain_loop_on = 1'b1;
      if (gain_acc < 0) gain_loop_on = 1'b0;

      if (gain_loop_on) begin
         if (regs.gain_switch_us == regs.shutter_max_us) begin
            gain_acc += round_down_shift(err * longint'(regs.gain_int_coef), 12);
            if (gain_acc > GAIN_ACC_LIMIT) gain_acc = GAIN_ACC_LIMIT;
            if (gain_acc < -GAIN_ACC_LIMIT) gain_acc = -GAIN_ACC_LIMIT;
            g = gain_acc + round_down_shift(err * GAIN_P_FACTOR, 12);
         end else begin
            over = shutter_q4 - sw16;
            span = longint'(regs.shutter_max_us) - longint'(regs.gain_switch_us);
            g    = over * longint'(regs.gain_max_db) * 16 / span;
         end
         if (g > gmax) g = gmax;
         if (g < 0) g = 0;
         gain_q8 = g;
      end else begin
         gain_acc = 0;
         gain_q8  = 0;
      end

      sh = shutter_q4 >>> 4;
      res.shutter_us      = sh[15:0];
      res.shutter_updated = ran;
      res.gain_level      = gain_q8[13:0];
      res.gain_mode       = gain_loop_on;
   endtask

   task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: beat %0d %s expected %0d actual %0d",
                  $time, frames_out, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         sensor_setting_q.delete();
         mismatches = 0;
         frames_in  <= 0;
         frames_out <= 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_TARGET_LEVEL:     regs.target_level     = csr_wr_data[11:0];
               CSR_DEAD_BAND:        regs.dead_band        = csr_wr_data[11:0];
               CSR_SHUTTER_MIN_US:   regs.shutter_min_us   = csr_wr_data;
               CSR_SHUTTER_MAX_US:   regs.shutter_max_us   = csr_wr_data;
               CSR_GAIN_MAX_DB:      regs.gain_max_db      = csr_wr_data[5:0];
               CSR_GAIN_SWITCH_US:   regs.gain_switch_us   = csr_wr_data;
               CSR_SHUTTER_INT_COEF: regs.shutter_int_coef = csr_wr_data;
               CSR_GAIN_INT_COEF:    regs.gain_int_coef    = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            run_exposure_step(req_mean_level, predicted);
            sensor_setting_q.push_back(predicted);
            frames_in <= frames_in + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (sensor_setting_q.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %0d/%0d/%0d/%0d",
                        $time, rsp_shutter_us, rsp_shutter_updated,
                        rsp_gain_level, rsp_gain_mode);
               mismatches++;
            end else begin
               returned = sensor_setting_q.pop_front();
               report_field("shutter_us", 16'(returned.shutter_us), 16'(rsp_shutter_us));
               report_field("shutter_updated", 16'(returned.shutter_updated),
                            16'(rsp_shutter_updated));
               report_field("gain_level", 16'(returned.gain_level), 16'(rsp_gain_level));
               report_field("gain_mode", 16'(returned.gain_mode), 16'(rsp_gain_mode));
               frames_out <= frames_out + 1;
            end
         end
      end
   end

endmodule

// ----- bench/tb_exposure_shutter_gain_pi_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exposure_shutter_gain_pi_controller_core
// Drives frame brightness beats into the exposure core under a sequence of
// register settings (defaults, PI gain, proportional gain, all-low, all-high,
// switch above max, min above max, random), with random input gaps and
// random result stalls. The monitor predicts and checks every result beat.
// ----------------------------------------------------------------------------
module tb_exposure_shutter_gain_pi_controller_core;
   import espi_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_FRAMES = 115;
   localparam int PHASES       = 10;

   typedef enum int {
      CFG_PI_GAIN, CFG_PROP_GAIN, CFG_ALL_LOW, CFG_ALL_HIGH,
      CFG_SWITCH_ABOVE, CFG_MIN_ABOVE, CFG_ANY
   } setting_kind_type;

   typedef enum int {SCENE_NEAR, SCENE_DARK, SCENE_BRIGHT, SCENE_NOISE} scene_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [11:0]           req_mean_level;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [15:0]           rsp_shutter_us;
   logic                  rsp_shutter_updated;
   logic [13:0]           rsp_gain_level;
   logic                  rsp_gain_mode;
   int                    mismatches;
   logic                  busy;

   int      cycles = 0;
   bit      calm = 1'b0;
   cfg_type live_cfg;

   exposure_shutter_gain_pi_controller_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mean_level      (req_mean_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_shutter_us      (rsp_shutter_us),
      .rsp_shutter_updated (rsp_shutter_updated),
      .rsp_gain_level      (rsp_gain_level),
      .rsp_gain_mode       (rsp_gain_mode)
   );

   exposure_result_monitor u_monitor (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mean_level      (req_mean_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_shutter_us      (rsp_shutter_us),
      .rsp_shutter_updated (rsp_shutter_updated),
      .rsp_gain_level      (rsp_gain_level),
      .rsp_gain_mode       (rsp_gain_mode),
      .mismatches          (mismatches),
      .busy                (busy)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("** exposure_shutter_gain_pi_controller_core: FAILED **");
      $finish;
   end

   function automatic cfg_type make_cfg(int t, int d, int mn, int mx, int gm, int sw,
                                        int sic, int gic);
      cfg_type c;
      c.target_level     = t[11:0];
      c.dead_band        = d[11:0];
      c.shutter_min_us   = mn[15:0];
      c.shutter_max_us   = mx[15:0];
      c.gain_max_db      = gm[5:0];
      c.gain_switch_us   = sw[15:0];
      c.shutter_int_coef = sic[15:0];
      c.gain_int_coef    = gic[15:0];
      return c;
   endfunction

   function automatic cfg_type make_settings(setting_kind_type kind);
      int smax, gsw;
      case (kind)
         CFG_PI_GAIN: begin
            smax = $urandom_range(1000, 65535);
            return make_cfg($urandom_range(200, 3900), $urandom_range(0, 200),
                            $urandom_range(0, smax / 4), smax, $urandom_range(0, 63), smax,
                            $urandom_range(16, 4096), $urandom_range(0, 65535));
         end
         CFG_PROP_GAIN: begin
            smax = $urandom_range(2000, 65535);
            gsw  = $urandom_range(0, smax - 1);
            return make_cfg($urandom_range(200, 3900), $urandom_range(0, 200),
                            $urandom_range(0, gsw), smax, $urandom_range(0, 63), gsw,
                            $urandom_range(16, 4096), $urandom_range(0, 65535));
         end
         CFG_ALL_LOW:  return make_cfg(0, 0, 0, 1, 0, 0, 0, 0);
         CFG_ALL_HIGH: return make_cfg(4095, 4095, 65535, 65535, 63, 65535, 65535, 65535);
         CFG_SWITCH_ABOVE: begin
            smax = $urandom_range(1, 60000);
            return make_cfg($urandom_range(0, 4095), $urandom_range(0, 300),
                            $urandom_range(0, 65535), smax, $urandom_range(0, 63),
                            $urandom_range(smax + 1, 65535), $urandom_range(16, 8192),
                            $urandom_range(0, 65535));
         end
         CFG_MIN_ABOVE: begin
            smax = $urandom_range(1, 50000);
            return make_cfg($urandom_range(0, 4095), $urandom_range(0, 300),
                            $urandom_range(smax + 1, 65535), smax, $urandom_range(0, 63),
                            $urandom_range(0, 65535), $urandom_range(16, 8192),
                            $urandom_range(0, 65535));
         end
         default:
            return make_cfg($urandom_range(0, 4095), $urandom_range(0, 4095),
                            $urandom_range(0, 65535), $urandom_range(1, 65535),
                            $urandom_range(0, 63), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535));
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [11:0] clamp_level(int v);
      if (v < 0) return 12'd0;
      if (v > 4095) return 12'd4095;
      return v[11:0];
   endfunction

   // leaves the register bus on the written value; caller lowers csr_wr_en
   task automatic write_reg(csr_index_type idx, logic [15:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(CSR_TARGET_LEVEL, {junk[15:12], c.target_level});
      write_reg(CSR_DEAD_BAND, {junk[11:8], c.dead_band});
      write_reg(CSR_SHUTTER_MIN_US, c.shutter_min_us);
      write_reg(CSR_SHUTTER_MAX_US, c.shutter_max_us);
      write_reg(CSR_GAIN_MAX_DB, {junk[9:0], c.gain_max_db});
      write_reg(CSR_GAIN_SWITCH_US, c.gain_switch_us);
      write_reg(CSR_SHUTTER_INT_COEF, c.shutter_int_coef);
      write_reg(CSR_GAIN_INT_COEF, c.gain_int_coef);
      csr_wr_en <= 1'b0;
      live_cfg = c;
   endtask

   task automatic send_frame(int level);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mean_level <= level[11:0];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (busy);
   endtask

   task automatic run_frames(int count, bit hold_mid);
      scene_type scene;
      int        level, left, t, d, n, v;
      left  = 0;
      level = 0;
      scene = SCENE_NOISE;
      for (n = 0; n < count; n++) begin
         t = int'(live_cfg.target_level);
         d = int'(live_cfg.dead_band);
         if (left == 0) begin
            left = $urandom_range(3, 25);
            v    = $urandom_range(0, 99);
            if (v < 30) scene = SCENE_NEAR;
            else if (v < 55) begin
               scene = SCENE_DARK;
               level = $urandom_range(0, t);
            end else if (v < 80) begin
               scene = SCENE_BRIGHT;
               level = $urandom_range(t, 4095);
            end else scene = SCENE_NOISE;
         end
         left--;
         case (scene)
            SCENE_NEAR:  v = t + $urandom_range(0, 2 * (d + 60)) - (d + 60);
            SCENE_NOISE: v = $urandom_range(0, 4095);
            default:     v = level + $urandom_range(0, 16) - 8;
         endcase
         if (hold_mid && n == count / 2) drain();
         send_frame(int'(clamp_level(v)));
      end
   endtask

   initial begin : rsp_side
      int len;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) rsp_stall <= 1'b0;
         else begin
            if ($urandom_range(0, 99) < 30) begin
               rsp_stall <= 1'b1;
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 12);
            end
            repeat (len - 1) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int               k;
      int               at_defaults[9] = '{0, 4095, 1600, 1520, 1521, 1679, 1680, 4095, 0};
      int               pi_swing[8]    = '{0, 0, 0, 4095, 4095, 4095, 2048, 0};
      int               prop_run[4]    = '{0, 0, 4095, 0};
      int               min_wins[3]    = '{0, 4095, 0};
      setting_kind_type plan[PHASES]   = '{CFG_PI_GAIN, CFG_PROP_GAIN, CFG_ALL_LOW,
                                           CFG_ALL_HIGH, CFG_SWITCH_ABOVE, CFG_MIN_ABOVE,
                                           CFG_ANY, CFG_PI_GAIN, CFG_PROP_GAIN, CFG_ANY};
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_mean_level <= 12'd0;
      csr_wr_en      <= 1'b0;
      csr_index      <= CSR_TARGET_LEVEL;
      csr_wr_data    <= 16'd0;
      live_cfg = make_cfg(1600, 80, 11, 20000, 48, 20000, 256, 3604);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: deadband edges and both error extremes
      foreach (at_defaults[k]) send_frame(at_defaults[k]);
      // fast PI loop: into gain mode, negative gain integral back out
      drain();
      apply_settings(make_cfg(2048, 16, 100, 30000, 63, 30000, 65535, 65535));
      foreach (pi_swing[k]) send_frame(pi_swing[k]);
      // proportional gain
      drain();
      apply_settings(make_cfg(2048, 16, 100, 30000, 63, 10000, 65535, 65535));
      foreach (prop_run[k]) send_frame(prop_run[k]);
      // min above max, switch above max, shutter below switch in gain mode
      drain();
      apply_settings(make_cfg(2048, 16, 50000, 20000, 63, 40000, 65535, 65535));
      foreach (min_wins[k]) send_frame(min_wins[k]);

      for (k = 0; k < PHASES; k++) begin
         drain();
         calm = (k == 2 || k == 7);
         apply_settings(make_settings(plan[k]));
         run_frames(PHASE_FRAMES, k % 3 == 1);
      end

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && !busy)
         $display("** exposure_shutter_gain_pi_controller_core: PASSED **");
      else
         $display("** exposure_shutter_gain_pi_controller_core: FAILED **");
      $finish;
   end

endmodule
